### src/sscc_pkg.sv
`timescale 1ns / 1ps
package sscc_pkg;
  localparam int PwmStepsDef = 20;
  localparam int AdcBitsDef  = 12;

  localparam logic [2:0] MENU_HOME   = 3'd0;
  localparam logic [2:0] MENU_BRIGHT = 3'd1;
  localparam logic [2:0] MENU_MODE   = 3'd2;
  localparam logic [2:0] MENU_SET_H  = 3'd3;
  localparam logic [2:0] MENU_SET_M  = 3'd4;

  localparam logic [1:0] VIEW_12   = 2'd0;
  localparam logic [1:0] VIEW_24   = 2'd1;
  localparam logic [1:0] VIEW_LONG = 2'd2;

  localparam logic [4:0] GLYPH_A     = 5'd10;
  localparam logic [4:0] GLYPH_P     = 5'd11;
  localparam logic [4:0] GLYPH_U     = 5'd14;
  localparam logic [4:0] GLYPH_S     = 5'd15;
  localparam logic [4:0] GLYPH_L     = 5'd16;
  localparam logic [4:0] GLYPH_BLANK = 5'd17;

  localparam logic [2:0] REG_TPS      = 3'd0;
  localparam logic [2:0] REG_PRESS    = 3'd1;
  localparam logic [2:0] REG_TIMEOUT  = 3'd2;
  localparam logic [2:0] REG_INTERVAL = 3'd3;
  localparam logic [2:0] REG_DARK     = 3'd4;
  localparam logic [2:0] REG_LIGHT    = 3'd5;

  // divide job handed to the serial divider
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

  function automatic logic [6:0] glyph(input logic [4:0] g);
    logic [6:0] s;
    begin
      case (g)
        5'd0: s = 7'h3F;  5'd1: s = 7'h06;  5'd2: s = 7'h5B;  5'd3: s = 7'h4F;
        5'd4: s = 7'h66;  5'd5: s = 7'h6D;  5'd6: s = 7'h7D;  5'd7: s = 7'h07;
        5'd8: s = 7'h7F;  5'd9: s = 7'h6F;  5'd10: s = 7'h77; 5'd11: s = 7'h73;
        5'd12: s = 7'h7C; 5'd13: s = 7'h50; 5'd14: s = 7'h1C; 5'd15: s = 7'h6D;
        5'd16: s = 7'h38;
        default: s = 7'h00;
      endcase
      return s;
    end
  endfunction

  // tens digit of a value below 64 (small constant table)
  function automatic logic [4:0] tens(input logic [5:0] v);
    logic [4:0] t;
    begin
      if (v >= 6'd60) t = 5'd6;
      else if (v >= 6'd50) t = 5'd5;
      else if (v >= 6'd40) t = 5'd4;
      else if (v >= 6'd30) t = 5'd3;
      else if (v >= 6'd20) t = 5'd2;
      else if (v >= 6'd10) t = 5'd1;
      else t = 5'd0;
      return t;
    end
  endfunction

  function automatic logic [4:0] ones(input logic [5:0] v);
    logic [5:0] r;
    begin
      r = v - 6'(tens(v)) * 6'd10;
      return r[4:0];
    end
  endfunction
endpackage

### src/sscc_divider.sv
`timescale 1ns / 1ps
module sscc_divider (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sscc_pkg::div_req_t   req,
  output sscc_pkg::div_rsp_t   rsp
);
  import sscc_pkg::*;

  logic [31:0] quo_r, quo_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [16:0] trial;

  // restoring division, one quotient bit per cycle
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[15:0], quo_r[31]};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

`ifndef SYNTHESIS
  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done held");
  a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != 6'd0) else $error("divider busy with zero count");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without work");
`endif
endmodule

### src/seven_segment_clock_controller_top.sv
`timescale 1ns / 1ps
// Flow: an accepted tick passes through ST_DIV, ST_UPD and ST_OUT; a tick
// with a brightness sample (valid window) waits in ST_UPD for the serial
// 32-step divider. One tick at a time: in_ready is low from acceptance until
// the result transfer and goes high again in the cycle after it.
// Reset: synchronous active-low rst_n; clock at 12:00:00, home menu, 12h view,
// auto brightness at level 20, registers at their defaults.
module seven_segment_clock_controller_top #(
  parameter int PWM_STEPS = sscc_pkg::PwmStepsDef,
  parameter int ADC_BITS  = sscc_pkg::AdcBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_button_down,
  input  logic        in_button_up,
  input  logic [11:0] in_adc_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_left_segments,
  output logic [6:0]  out_right_segments,
  output logic        out_backlight_on,
  output logic [4:0]  out_brightness,
  output logic [2:0]  out_menu_mode,
  output logic [1:0]  out_view_mode,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import sscc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  localparam logic [4:0] PwmMax = 5'(PWM_STEPS);

  state_t state_r, state_nxt;

  // configuration
  logic [15:0] tps_r, timeout_r, interval_r;
  logic [9:0]  press_r;
  logic [11:0] dark_r, light_r;
  logic        cfg_we;
  logic [2:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_we  = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= 16'd1000; press_r <= 10'd50; timeout_r <= 16'd5000;
      interval_r <= 16'd1000; dark_r <= 12'd3600; light_r <= 12'd3200;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_TPS:      tps_r <= cfg_pwdata[15:0];
        REG_PRESS:    press_r <= cfg_pwdata[9:0];
        REG_TIMEOUT:  timeout_r <= cfg_pwdata[15:0];
        REG_INTERVAL: interval_r <= cfg_pwdata[15:0];
        REG_DARK:     dark_r <= cfg_pwdata[11:0];
        REG_LIGHT:    light_r <= cfg_pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TPS:      cfg_prdata = {16'd0, tps_r};
      REG_PRESS:    cfg_prdata = {22'd0, press_r};
      REG_TIMEOUT:  cfg_prdata = {16'd0, timeout_r};
      REG_INTERVAL: cfg_prdata = {16'd0, interval_r};
      REG_DARK:     cfg_prdata = {20'd0, dark_r};
      REG_LIGHT:    cfg_prdata = {20'd0, light_r};
      default:      cfg_prdata = '0;
    endcase
  end

  // state
  logic [15:0] ms_r, idle_r, samp_r;
  logic [5:0]  sec_r, min_r;
  logic [4:0]  hour_r, level_r, phase_r;
  logic [2:0]  menu_r, step_r;
  logic [1:0]  view_r;
  logic        auto_r, both_r;
  logic [9:0]  hold_r [2];
  logic [1:0]  latch_r, ign_r;
  logic        rd_dn_r, rd_up_r;
  logic [11:0] adc_r;

  logic [15:0] ms_n, idle_n, samp_n;
  logic [5:0]  sec_n, min_n;
  logic [4:0]  hour_n, level_n, phase_n;
  logic [2:0]  menu_n, step_n;
  logic [1:0]  view_n;
  logic        auto_n, both_n;
  logic [9:0]  hold_n [2];
  logic [1:0]  latch_n, ign_n;
  logic [6:0]  segl_n, segr_n;
  logic [6:0]  segl_r, segr_r;
  logic        bl_r, bl_n;

  // divider interface
  div_req_t dreq;
  div_rsp_t drsp;
  logic     samp_due;
  logic [11:0] adc_m, clampv;
  logic [15:0] span;

  sscc_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign adc_m   = in_adc_sample & 12'((1 << ADC_BITS) - 1);
  assign samp_due = auto_r && ((samp_r == 16'hFFFF ? samp_r : samp_r + 16'd1) > interval_r);
  assign clampv  = (adc_r > dark_r) ? dark_r : ((adc_r < light_r) ? light_r : adc_r);
  assign span    = {4'd0, dark_r - light_r};

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  always_comb begin
    state_nxt = state_r;
    dreq.start    = 1'b0;
    dreq.dividend = 32'(dark_r - clampv) * 32'(PWM_STEPS - 1);
    dreq.divisor  = span;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_DIV;
      ST_DIV: begin
        // a sample with a valid window uses the divider
        if (samp_due && dark_r > light_r) begin
          dreq.start = 1'b1;
          state_nxt = ST_UPD;
        end else state_nxt = ST_UPD;
      end
      ST_UPD: if (!(samp_due && dark_r > light_r) || drsp.done) state_nxt = ST_OUT;
      ST_OUT: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // per-tick update, evaluated in ST_UPD
  logic        rd [2];
  logic [4:0]  h12, lg, rg;
  logic [5:0]  c15, c60;
  always_comb begin
    ms_n = ms_r; idle_n = idle_r; samp_n = samp_r; sec_n = sec_r; min_n = min_r;
    hour_n = hour_r; level_n = level_r; phase_n = phase_r; menu_n = menu_r;
    step_n = step_r; view_n = view_r; auto_n = auto_r; both_n = both_r;
    hold_n[0] = hold_r[0]; hold_n[1] = hold_r[1]; latch_n = latch_r; ign_n = ign_r;
    rd[0] = rd_dn_r; rd[1] = rd_up_r;
    lg = GLYPH_BLANK; rg = GLYPH_BLANK; h12 = '0; c15 = '0; c60 = '0;

    if (idle_n != 16'hFFFF) idle_n = idle_n + 16'd1;
    if (samp_n != 16'hFFFF) samp_n = samp_n + 16'd1;
    for (int i = 0; i < 2; i++)
      if (latch_r[i] && hold_n[i] != 10'h3FF) hold_n[i] = hold_n[i] + 10'd1;

    if (ms_n != 16'hFFFF) ms_n = ms_n + 16'd1;
    if (ms_n >= tps_r) begin
      ms_n = '0;
      if (sec_n == 6'd59) begin
        sec_n = '0;
        if (min_n == 6'd59) begin
          min_n = '0;
          hour_n = (hour_n == 5'd23) ? 5'd0 : hour_n + 5'd1;
        end else min_n = min_n + 6'd1;
      end else sec_n = sec_n + 6'd1;
    end

    if (samp_due) begin
      samp_n = '0;
      if (dark_r <= light_r) level_n = PwmMax;
      else level_n = 5'd1 + drsp.quotient[4:0];
    end

    if (rd[0] && rd[1]) begin
      if (!both_r) begin
        if (menu_n == MENU_HOME) menu_n = MENU_SET_H;
        else if (menu_n == MENU_SET_H) menu_n = MENU_SET_M;
        else if (menu_n == MENU_SET_M) begin
          menu_n = MENU_HOME;
          sec_n = '0;
        end
        idle_n = '0;
        both_n = 1'b1;
      end
      latch_n = 2'b11;
      ign_n = 2'b11;
    end else begin
      if (!rd[0] && !rd[1]) both_n = 1'b0;
      for (int i = 0; i < 2; i++) begin
        if (rd[i] && !latch_n[i]) begin
          hold_n[i] = '0;
          latch_n[i] = 1'b1;
          ign_n[i] = 1'b0;
        end
        if (!rd[i] && latch_n[i]) begin
          latch_n[i] = 1'b0;
          if (ign_n[i]) ign_n[i] = 1'b0;
          else if (hold_n[i] > press_r) begin
            idle_n = '0;
            if (i == 0) begin
              if (menu_n == MENU_HOME) menu_n = MENU_BRIGHT;
              else if (menu_n == MENU_BRIGHT) begin
                if (auto_n) begin
                  auto_n = 1'b0; step_n = 3'd1; level_n = 5'd1;
                end else if (step_n == 3'd1) begin
                  step_n = 3'd2; level_n = 5'd3;
                end else if (step_n == 3'd2) begin
                  step_n = 3'd3; level_n = 5'd8;
                end else if (step_n == 3'd3) begin
                  step_n = 3'd4; level_n = PwmMax;
                end else auto_n = 1'b1;
              end else if (menu_n == MENU_SET_H)
                hour_n = (hour_n == 5'd0) ? 5'd23 : hour_n - 5'd1;
              else if (menu_n == MENU_SET_M)
                min_n = (min_n == 6'd0) ? 6'd59 : min_n - 6'd1;
            end else begin
              if (menu_n == MENU_HOME) begin
                menu_n = MENU_MODE;
                view_n = (view_n == VIEW_12) ? VIEW_24 :
                         ((view_n == VIEW_24) ? VIEW_LONG : VIEW_12);
              end else if (menu_n == MENU_SET_H)
                hour_n = (hour_n == 5'd23) ? 5'd0 : hour_n + 5'd1;
              else if (menu_n == MENU_SET_M)
                min_n = (min_n == 6'd59) ? 6'd0 : min_n + 6'd1;
            end
          end
        end
      end
    end

    if ((menu_n == MENU_BRIGHT || menu_n == MENU_MODE) && idle_n > timeout_r)
      menu_n = MENU_HOME;

    h12 = (hour_n == 5'd0) ? 5'd12 : ((hour_n > 5'd12) ? hour_n - 5'd12 : hour_n);
    c15 = (sec_n >= 6'd45) ? sec_n - 6'd45 : (sec_n >= 6'd30) ? sec_n - 6'd30 :
          (sec_n >= 6'd15) ? sec_n - 6'd15 : sec_n;
    c60 = sec_n;
    case (menu_n)
      MENU_HOME: begin
        if (view_n == VIEW_12 || view_n == VIEW_LONG) begin
          if ((view_n == VIEW_12 && c15 < 6'd6) || (view_n == VIEW_LONG && c60 < 6'd50)) begin
            lg = (h12 >= 5'd10) ? 5'd1 : GLYPH_BLANK;
            rg = ones({1'b0, h12});
          end else if ((view_n == VIEW_12 && c15 < 6'd12) ||
                       (view_n == VIEW_LONG && c60 < 6'd55)) begin
            lg = tens(min_n); rg = ones(min_n);
          end else begin
            lg = GLYPH_BLANK; rg = (hour_n < 5'd12) ? GLYPH_A : GLYPH_P;
          end
        end else if (view_n == VIEW_24) begin
          if (c15 < 6'd10) begin
            lg = tens({1'b0, hour_n}); rg = ones({1'b0, hour_n});
          end else begin
            lg = tens(min_n); rg = ones(min_n);
          end
        end
      end
      MENU_BRIGHT: begin
        if (auto_n) begin lg = GLYPH_A; rg = GLYPH_U; end
        else begin lg = GLYPH_L; rg = {2'b00, step_n}; end
      end
      MENU_MODE: begin
        if (view_n == VIEW_12) begin lg = 5'd1; rg = 5'd2; end
        else if (view_n == VIEW_24) begin lg = 5'd2; rg = 5'd4; end
        else if (view_n == VIEW_LONG) begin lg = GLYPH_S; rg = GLYPH_L; end
      end
      MENU_SET_H: begin lg = tens({1'b0, hour_n}); rg = ones({1'b0, hour_n}); end
      MENU_SET_M: begin lg = tens(min_n); rg = ones(min_n); end
      default: ;
    endcase
    segl_n = glyph(lg);
    segr_n = glyph(rg);

    phase_n = (phase_r >= PwmMax) ? 5'd1 : phase_r + 5'd1;
    bl_n = (phase_n <= level_n);
  end

  logic commit;
  assign commit = (state_r == ST_UPD) && (state_nxt == ST_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ms_r <= '0; sec_r <= '0; min_r <= '0; hour_r <= 5'd12;
      menu_r <= MENU_HOME; view_r <= VIEW_12; auto_r <= 1'b1; step_r <= 3'd4;
      level_r <= PwmMax; phase_r <= '0; idle_r <= '0; samp_r <= '0;
      hold_r[0] <= '0; hold_r[1] <= '0; latch_r <= '0; ign_r <= '0; both_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        ms_r <= ms_n; sec_r <= sec_n; min_r <= min_n; hour_r <= hour_n;
        menu_r <= menu_n; view_r <= view_n; auto_r <= auto_n; step_r <= step_n;
        level_r <= level_n; phase_r <= phase_n; idle_r <= idle_n; samp_r <= samp_n;
        hold_r[0] <= hold_n[0]; hold_r[1] <= hold_n[1];
        latch_r <= latch_n; ign_r <= ign_n; both_r <= both_n;
      end
    end
    if (in_valid && in_ready) begin
      rd_dn_r <= in_button_down; rd_up_r <= in_button_up; adc_r <= adc_m;
    end
    if (commit) begin
      segl_r <= segl_n; segr_r <= segr_n; bl_r <= bl_n;
    end
  end

  assign out_left_segments  = segl_r;
  assign out_right_segments = segr_r;
  assign out_backlight_on   = bl_r;
  assign out_brightness     = level_r;
  assign out_menu_mode      = menu_r;
  assign out_view_mode      = view_r;

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    level_r != 5'd0 && level_r <= PwmMax) else $error("level out of range");
  a_menu: assert property (@(posedge clk) disable iff (!rst_n)
    menu_r <= MENU_SET_M) else $error("bad menu");
`endif
endmodule
